FILE: design/lcs_pkg.sv
package lcs_pkg;

  // one loaded element of either sequence
  typedef struct packed {
    logic        seq_select;
    logic [15:0] element;
    logic        last_of_seq;
  } lcs_in_t;

  // one emitted element of the common subsequence
  typedef struct packed {
    logic [15:0] common_element;
    logic [5:0]  common_length;
    logic        is_last;
    logic        none_found;
    logic        truncated;
  } lcs_out_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_TB_RD,
    ST_TB_CHK,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } lcs_state_e;

  // selector values of the input transaction
  localparam logic SEL_FIRST  = 1'b0;
  localparam logic SEL_SECOND = 1'b1;

endpackage

FILE: design/lcs_cell_unit.sv
module lcs_cell_unit #(
  parameter int SW = 16,
  parameter int VW = 6
) (
  input  logic [SW-1:0] a_i,
  input  logic [SW-1:0] b_i,
  input  logic [VW-1:0] up_i,
  input  logic [VW-1:0] left_i,
  input  logic [VW-1:0] diag_i,
  input  logic [VW-1:0] cell_i,
  input  logic [VW-1:0] level_i,
  output logic [VW-1:0] value_o,
  output logic          hit_o
);

  logic match;

  // element compare shared by fill and traceback
  assign match = (a_i == b_i);

  // table recurrence: diagonal plus one on a match, else larger neighbor
  always_comb begin
    if (match) begin
      value_o = diag_i + VW'(1);
    end else if (up_i > left_i) begin
      value_o = up_i;
    end else begin
      value_o = left_i;
    end
  end

  // traceback hit: cell at the wanted level on matching elements
  assign hit_o = match && (cell_i == level_i);

endmodule

FILE: design/longest_common_subsequence_unit.sv
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------
// input     | start_i & !busy_o    | in_i  (seq_select, element, last_of_seq)
// result    | result_valid_o       | result_o (one cycle, no stall)
//
// loading takes one element per cycle while busy_o is low; the pair closes on the second last mark
// fill then visits each table cell in a read then a write state (n1*n2 cells, one read port on table)
// traceback scans each cell in a read then a check state, each result passes a read then an output state
// busy_o is high from after pair close and drops as the last result is shown
// rst_ni clears the loader and sequencer; memories need no clearing
module longest_common_subsequence_unit #(
  parameter int MAX_LEN  = 32,
  parameter int ID_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  lcs_pkg::lcs_in_t  in_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output lcs_pkg::lcs_out_t result_o
);
  import lcs_pkg::*;

  localparam int SW = (ID_WIDTH < 16) ? ID_WIDTH : 16;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int VW = CW;
  localparam int D  = MAX_LEN + 1;
  localparam int TW = $clog2(D * D);

  lcs_state_e state_q, state_d;

  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic          done_a_q, done_a_d, done_b_q, done_b_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, r_q, r_d, c_q, c_d, cb_q, cb_d;
  logic [VW-1:0] diag_q, diag_d, left_q, left_d, total_q, total_d, level_q, level_d;
  logic [AW-1:0] k_q, k_d;
  logic          result_valid_q, result_valid_d;
  lcs_out_t      result_q, result_d;

  // memories
  logic [SW-1:0] mem_a [MAX_LEN];
  logic [SW-1:0] mem_b [MAX_LEN];
  logic [VW-1:0] mem_t [D*D];
  logic [SW-1:0] mem_ans [MAX_LEN];
  logic [SW-1:0] a_rd_q, b_rd_q, ans_rd_q;
  logic [VW-1:0] t_rd_q;

  logic          we_a, we_b, we_t, we_ans;
  logic [AW-1:0] wa_a, wa_b, ra_a, ra_b, wa_ans;
  logic [TW-1:0] wa_t, ra_t;
  logic [VW-1:0] wd_t;

  logic          accept, close_pair;
  logic [SW-1:0] elem;
  logic [VW-1:0] up_val, cell_val;
  logic          hit, fill_end, tb_fail, tb_done, emit_end, none;

  assign accept = start_i && (state_q == ST_IDLE);
  assign elem   = in_i.element[SW-1:0];

  // loader next values
  always_comb begin
    cnt_a_d  = cnt_a_q;
    cnt_b_d  = cnt_b_q;
    done_a_d = done_a_q;
    done_b_d = done_b_q;
    ovf_d    = ovf_q;
    we_a     = 1'b0;
    we_b     = 1'b0;
    if (accept) begin
      if (in_i.seq_select == SEL_FIRST) begin
        if (!done_a_q) begin
          if (cnt_a_q < CW'(MAX_LEN)) begin
            we_a    = 1'b1;
            cnt_a_d = cnt_a_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last_of_seq) done_a_d = 1'b1;
        end
      end else begin
        if (!done_b_q) begin
          if (cnt_b_q < CW'(MAX_LEN)) begin
            we_b    = 1'b1;
            cnt_b_d = cnt_b_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last_of_seq) done_b_d = 1'b1;
        end
      end
    end
    if (state_q == ST_EMIT_OUT && emit_end) begin
      cnt_a_d  = '0;
      cnt_b_d  = '0;
      done_a_d = 1'b0;
      done_b_d = 1'b0;
      ovf_d    = 1'b0;
    end
  end

  assign close_pair = accept && done_a_d && done_b_d;
  assign wa_a = cnt_a_q[AW-1:0];
  assign wa_b = cnt_b_q[AW-1:0];

  // shared compare and max unit
  assign up_val = (i_q == CW'(1)) ? '0 : t_rd_q;

  lcs_cell_unit #(.SW(SW), .VW(VW)) u_cell (
    .a_i     (a_rd_q),
    .b_i     (b_rd_q),
    .up_i    (up_val),
    .left_i  (left_q),
    .diag_i  (diag_q),
    .cell_i  (t_rd_q),
    .level_i (level_q),
    .value_o (cell_val),
    .hit_o   (hit)
  );

  // sequencer decisions
  assign fill_end = (i_q == cnt_a_q) && (j_q == cnt_b_q);
  assign tb_done  = hit && (level_q == VW'(1));
  assign tb_fail  = hit ? (!tb_done && (r_q == CW'(1) || c_q == CW'(1)))
                        : (c_q == CW'(1) && r_q == CW'(1));
  assign none     = (total_q == '0);
  assign emit_end = none || (k_q == AW'(total_q - VW'(1)));

  // read addresses by phase
  always_comb begin
    ra_a = AW'(i_q - CW'(1));
    ra_b = AW'(j_q - CW'(1));
    ra_t = TW'(i_q - CW'(1)) * TW'(D) + TW'(j_q);
    if (state_q == ST_TB_RD) begin
      ra_a = AW'(r_q - CW'(1));
      ra_b = AW'(c_q - CW'(1));
      ra_t = TW'(r_q) * TW'(D) + TW'(c_q);
    end
  end

  assign we_t   = (state_q == ST_FILL_WR);
  assign wa_t   = TW'(i_q) * TW'(D) + TW'(j_q);
  assign wd_t   = cell_val;
  assign we_ans = (state_q == ST_TB_CHK) && hit;
  assign wa_ans = AW'(level_q - VW'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (close_pair) state_d = ST_FILL_RD;
      ST_FILL_RD:  state_d = ST_FILL_WR;
      ST_FILL_WR: begin
        if (!fill_end) state_d = ST_FILL_RD;
        else if (cell_val == '0) state_d = ST_EMIT_RD;
        else state_d = ST_TB_RD;
      end
      ST_TB_RD:    state_d = ST_TB_CHK;
      ST_TB_CHK:   state_d = (tb_done || tb_fail) ? ST_EMIT_RD : ST_TB_RD;
      ST_EMIT_RD:  state_d = ST_EMIT_OUT;
      ST_EMIT_OUT: state_d = emit_end ? ST_IDLE : ST_EMIT_RD;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath registers by phase
  always_comb begin
    i_d            = i_q;
    j_d            = j_q;
    r_d            = r_q;
    c_d            = c_q;
    cb_d           = cb_q;
    diag_d         = diag_q;
    left_d         = left_q;
    total_d        = total_q;
    level_d        = level_q;
    k_d            = k_q;
    result_valid_d = 1'b0;
    result_d       = result_q;
    case (state_q)
      ST_IDLE: begin
        i_d    = CW'(1);
        j_d    = CW'(1);
        diag_d = '0;
        left_d = '0;
      end
      ST_FILL_WR: begin
        if (j_q == cnt_b_q) begin
          j_d    = CW'(1);
          i_d    = i_q + CW'(1);
          diag_d = '0;
          left_d = '0;
        end else begin
          j_d    = j_q + CW'(1);
          diag_d = up_val;
          left_d = cell_val;
        end
        total_d = cell_val;
        level_d = cell_val;
        r_d     = cnt_a_q;
        c_d     = cnt_b_q;
        cb_d    = cnt_b_q;
        k_d     = '0;
      end
      ST_TB_CHK: begin
        if (hit) begin
          level_d = level_q - VW'(1);
          r_d     = r_q - CW'(1);
          c_d     = c_q - CW'(1);
          cb_d    = c_q - CW'(1);
        end else if (c_q != CW'(1)) begin
          c_d = c_q - CW'(1);
        end else begin
          r_d = r_q - CW'(1);
          c_d = cb_q;
        end
        if (tb_fail) total_d = '0;
      end
      ST_EMIT_OUT: begin
        result_valid_d          = 1'b1;
        result_d.common_element = none ? 16'd0 : 16'(ans_rd_q);
        result_d.common_length  = 6'(total_q);
        result_d.is_last        = emit_end;
        result_d.none_found     = none;
        result_d.truncated      = ovf_q;
        k_d                     = k_q + AW'(1);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_a_q        <= '0;
      cnt_b_q        <= '0;
      done_a_q       <= 1'b0;
      done_b_q       <= 1'b0;
      ovf_q          <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      cnt_a_q        <= cnt_a_d;
      cnt_b_q        <= cnt_b_d;
      done_a_q       <= done_a_d;
      done_b_q       <= done_b_d;
      ovf_q          <= ovf_d;
      result_valid_q <= result_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    j_q      <= j_d;
    r_q      <= r_d;
    c_q      <= c_d;
    cb_q     <= cb_d;
    diag_q   <= diag_d;
    left_q   <= left_d;
    total_q  <= total_d;
    level_q  <= level_d;
    k_q      <= k_d;
    result_q <= result_d;
  end

  // sequence stores
  always_ff @(posedge clk_i) begin
    if (we_a) mem_a[wa_a] <= elem;
    a_rd_q <= mem_a[ra_a];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) mem_b[wa_b] <= elem;
    b_rd_q <= mem_b[ra_b];
  end

  // length table
  always_ff @(posedge clk_i) begin
    if (we_t) mem_t[wa_t] <= wd_t;
    t_rd_q <= mem_t[ra_t];
  end

  // answer buffer
  always_ff @(posedge clk_i) begin
    if (we_ans) mem_ans[wa_ans] <= a_rd_q;
    ans_rd_q <= mem_ans[k_q];
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

FILE: design/lcs_checker.sv
module lcs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input lcs_pkg::lcs_in_t  in_i,
  input logic              busy_o,
  input logic              result_valid_o,
  input lcs_pkg::lcs_out_t result_o
);
  import lcs_pkg::*;

  // a run continues only while the unit stays busy
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.is_last |-> busy_o)
    else $error("result run left busy early");

  // the no-match result stands alone with a zero element
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.none_found |->
      result_o.is_last && (result_o.common_element == 16'd0))
    else $error("malformed none-found result");

  // results of one run are spaced apart
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.is_last |=> !result_valid_o)
    else $error("results back to back");

  // an accepted load transaction is never answered in the next cycle
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> !result_valid_o)
    else $error("result right after load transaction");

endmodule

bind longest_common_subsequence_unit lcs_checker u_lcs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .in_i           (in_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

FILE: verif/longest_common_subsequence_unit_tb.sv
module longest_common_subsequence_unit_tb;
  import lcs_pkg::*;

  localparam int MaxLen     = 32;
  localparam int CycleLimit = 1500000;

  // one row of the directed stimulus table
  typedef struct {
    lcs_in_t  item;
    bit       typed;
    lcs_out_t typed_res;
  } stim_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  lcs_in_t  in_i;
  logic     busy_o;
  logic     result_valid_o;
  lcs_out_t result_o;

  // predictor state
  logic [15:0] first_seq [MaxLen];
  logic [15:0] second_seq[MaxLen];
  int          first_len, second_len;
  bit          first_closed, second_closed, dropped;
  int          lcs_tbl[MaxLen+1][MaxLen+1];

  lcs_out_t    expected_common[$];
  int          fail_cnt;
  int          cycle_cnt;
  int          loaded_cnt;

  longest_common_subsequence_unit i_dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .in_i,
    .busy_o,
    .result_valid_o,
    .result_o
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // append one expected result at the tail of the queue
  task automatic add_expected(input lcs_out_t res);
    expected_common = {expected_common, res};
  endtask

  // fill the table and trace one common subsequence back, queue its results unless suppressed
  task automatic predict_common(input bit suppress);
    logic [15:0] answer[MaxLen];
    int total, rb, cb, got, r, c;
    bit hit;
    lcs_out_t res;
    for (int i = 0; i <= first_len; i++) begin
      for (int j = 0; j <= second_len; j++) begin
        if (i == 0 || j == 0) begin
          lcs_tbl[i][j] = 0;
        end else if (first_seq[i-1] == second_seq[j-1]) begin
          lcs_tbl[i][j] = lcs_tbl[i-1][j-1] + 1;
        end else begin
          lcs_tbl[i][j] = (lcs_tbl[i-1][j] > lcs_tbl[i][j-1]) ?
                          lcs_tbl[i-1][j] : lcs_tbl[i][j-1];
        end
      end
    end
    total = lcs_tbl[first_len][second_len];
    rb    = first_len;
    cb    = second_len;
    got   = 0;
    for (int lvl = total; lvl > 0; lvl--) begin
      hit = 1'b0;
      for (r = rb; r >= 1 && !hit; r--) begin
        for (c = cb; c >= 1; c--) begin
          if (lcs_tbl[r][c] == lvl && first_seq[r-1] == second_seq[c-1]) begin
            answer[lvl-1] = first_seq[r-1];
            got++;
            rb  = r - 1;
            cb  = c - 1;
            hit = 1'b1;
            break;
          end
        end
      end
      if (!hit) break;
    end
    if (got != total) total = 0;
    if (!suppress) begin
      if (total == 0) begin
        res = '{common_element: '0, common_length: '0, is_last: 1'b1,
                none_found: 1'b1, truncated: dropped};
        add_expected(res);
      end else begin
        for (int k = 0; k < total; k++) begin
          res = '{common_element: answer[k], common_length: 6'(total),
                  is_last: (k == total - 1), none_found: 1'b0, truncated: dropped};
          add_expected(res);
        end
      end
    end
    first_len     = 0;
    second_len    = 0;
    first_closed  = 1'b0;
    second_closed = 1'b0;
    dropped       = 1'b0;
  endtask

  // update the loader model for one accepted transaction
  task automatic load_element(input lcs_in_t it, input bit suppress);
    if (it.seq_select == SEL_FIRST) begin
      if (first_closed) return;
      if (first_len < MaxLen) first_seq[first_len++] = it.element;
      else dropped = 1'b1;
      if (it.last_of_seq) first_closed = 1'b1;
    end else begin
      if (second_closed) return;
      if (second_len < MaxLen) second_seq[second_len++] = it.element;
      else dropped = 1'b1;
      if (it.last_of_seq) second_closed = 1'b1;
    end
    if (first_closed && second_closed) predict_common(suppress);
  endtask

  // random sender gap: mostly none, some short, a few long
  task automatic sender_gap();
    int n, pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) n = 0;
    else if (pick < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // present one transaction and wait until it is taken
  task automatic send_item(input lcs_in_t it, input bit typed, input lcs_out_t typed_res);
    sender_gap();
    start_i <= 1'b1;
    in_i    <= it;
    do @(posedge clk_i); while (busy_o);
    load_element(it, typed);
    if (typed) add_expected(typed_res);
    @(negedge clk_i);
  endtask

  // one pair with interleaved loading and optional stray elements
  task automatic send_pair(input int n1, input int n2, input bit identical, input int alpha);
    logic [15:0] pool[4];
    logic [15:0] a[$], b[$];
    lcs_in_t it;
    int ia, ib;
    bit side;
    foreach (pool[k]) pool[k] = 16'($urandom);
    for (int k = 0; k < n1; k++)
      a = {a, (alpha == 0 ? 16'($urandom) : pool[$urandom_range(0, alpha - 1)])};
    for (int k = 0; k < n2; k++)
      b = {b, ((identical && k < n1) ? a[k] :
               (alpha == 0 ? 16'($urandom) : pool[$urandom_range(0, alpha - 1)]))};
    ia = 0;
    ib = 0;
    while (ia < n1 || ib < n2) begin
      if (ia >= n1) side = SEL_SECOND;
      else if (ib >= n2) side = SEL_FIRST;
      else side = 1'($urandom_range(0, 1));
      // stray element for a sequence that is already closed
      if ((ia >= n1 || ib >= n2) && $urandom_range(0, 5) == 0) begin
        it = '{seq_select: ~side, element: 16'($urandom),
               last_of_seq: 1'($urandom_range(0, 1))};
        send_item(it, 1'b0, '0);
      end
      if (side == SEL_FIRST) begin
        it = '{seq_select: SEL_FIRST, element: a[ia], last_of_seq: (ia == n1 - 1)};
        ia++;
      end else begin
        it = '{seq_select: SEL_SECOND, element: b[ib], last_of_seq: (ib == n2 - 1)};
        ib++;
      end
      send_item(it, 1'b0, '0);
      loaded_cnt++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    lcs_out_t exp_res;
    if (rst_ni && result_valid_o) begin
      if (expected_common.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result_o);
        fail_cnt++;
      end else begin
        exp_res = expected_common.pop_front();
        if (result_o.common_element !== exp_res.common_element ||
            result_o.common_length  !== exp_res.common_length  ||
            result_o.is_last        !== exp_res.is_last        ||
            result_o.none_found     !== exp_res.none_found     ||
            result_o.truncated      !== exp_res.truncated) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_res, result_o);
          fail_cnt++;
        end
      end
    end
  end

  stim_row_t directed[$];

  initial begin
    int kind;
    fail_cnt      = 0;
    cycle_cnt     = 0;
    loaded_cnt    = 0;
    first_len     = 0;
    second_len    = 0;
    first_closed  = 1'b0;
    second_closed = 1'b0;
    dropped       = 1'b0;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    in_i    = '0;

    // extremes with nothing shared, one shared element, stray element,
    // and short overlapping sequences
    directed = '{
      '{'{SEL_FIRST,  16'hFFFF, 1'b1}, 1'b0, '0},
      '{'{SEL_SECOND, 16'h0000, 1'b1}, 1'b1, '{16'h0000, 6'd0, 1'b1, 1'b1, 1'b0}},
      '{'{SEL_SECOND, 16'hABCD, 1'b1}, 1'b0, '0},
      '{'{SEL_FIRST,  16'hABCD, 1'b1}, 1'b1, '{16'hABCD, 6'd1, 1'b1, 1'b0, 1'b0}},
      '{'{SEL_FIRST,  16'h0005, 1'b1}, 1'b0, '0},
      '{'{SEL_FIRST,  16'h0007, 1'b0}, 1'b0, '0},
      '{'{SEL_SECOND, 16'h0005, 1'b1}, 1'b1, '{16'h0005, 6'd1, 1'b1, 1'b0, 1'b0}},
      '{'{SEL_FIRST,  16'h0001, 1'b0}, 1'b0, '0},
      '{'{SEL_SECOND, 16'h0002, 1'b0}, 1'b0, '0},
      '{'{SEL_FIRST,  16'h0002, 1'b0}, 1'b0, '0},
      '{'{SEL_FIRST,  16'h0003, 1'b1}, 1'b0, '0},
      '{'{SEL_SECOND, 16'h0003, 1'b1}, 1'b0, '0},
      '{'{SEL_FIRST,  16'h8000, 1'b0}, 1'b0, '0},
      '{'{SEL_FIRST,  16'h7FFF, 1'b0}, 1'b0, '0},
      '{'{SEL_FIRST,  16'h8000, 1'b1}, 1'b0, '0},
      '{'{SEL_SECOND, 16'h7FFF, 1'b0}, 1'b0, '0},
      '{'{SEL_SECOND, 16'h8000, 1'b0}, 1'b0, '0},
      '{'{SEL_SECOND, 16'h8000, 1'b1}, 1'b0, '0}
    };

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[r]) begin
      send_item(directed[r].item, directed[r].typed, directed[r].typed_res);
      loaded_cnt++;
    end

    // full capacity identical pair, then overflow on both sides
    send_pair(MaxLen, MaxLen, 1'b1, 2);
    send_pair(MaxLen + 2, 3, 1'b1, 3);
    send_pair(2, MaxLen + 3, 1'b0, 2);

    // random pairs, mostly short with a small alphabet
    while (loaded_cnt < 320) begin
      kind = $urandom_range(0, 99);
      if (kind < 80)
        send_pair($urandom_range(1, 8), $urandom_range(1, 8), 1'b0, $urandom_range(1, 4));
      else if (kind < 88)
        send_pair($urandom_range(1, 6), $urandom_range(1, 6), 1'b0, 0);
      else if (kind < 95)
        send_pair($urandom_range(4, 12), $urandom_range(4, 12), 1'b1, 3);
      else
        send_pair($urandom_range(1, MaxLen + 4), $urandom_range(1, MaxLen + 4), 1'b0,
                  $urandom_range(1, 4));
    end
    start_i <= 1'b0;

    // drain
    while (expected_common.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
